// ===== src/sha1_pkg.sv =====
// Shared types and constants for the SHA-1 byte stream hasher.
package sha1_pkg;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned QUEUE_DEPTH = 2;

	// classified request passed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} sha1_req_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] d;
		begin
			d = {v, v} << n;
			rotl = d[63:32];
		end
	endfunction

endpackage

// ===== src/sha1_front.sv =====
// Front end: accept requests, drop empty ones, queue the rest.
module sha1_front import sha1_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       end_of_message,
	output logic       q_valid,
	input  logic       q_ready,
	output sha1_req_t  q_req
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha1_req_t           mem_q [DEPTH];
	logic [AW-1:0]       wr_q, rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic                push, pop, useful;

	assign in_ready = (cnt_q != DEPTH[$clog2(DEPTH+1)-1:0]);
	assign useful   = has_byte | end_of_message;
	assign push     = in_valid & in_ready & useful;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid & q_ready;
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{data_byte, has_byte, end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == DEPTH[$clog2(DEPTH+1)-1:0] |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !pop) else $error("queue underflow");
	a_empty_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !useful) |=> cnt_q <= $past(cnt_q))
		else $error("empty request queued");
`endif
endmodule

// ===== src/sha1_back.sv =====
// Back end: byte packing, padding, 80-round compression, digest output.
module sha1_back import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  sha1_req_t   q_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	typedef enum logic [2:0] {
		S_IDLE, S_PAD, S_COMP, S_ADD, S_LEN, S_EMIT
	} state_t;

	state_t       state_q;
	logic [31:0]  w_q [16];
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic         fin_q;      // finalizing: compression ends in padding path
	logic         need2_q;    // padding needs a second block
	logic         pad_done_q; // padding already written for this message
	logic [3:0]   widx_q;     // padding clear index
	logic [2:0]   oidx_q;

	logic [31:0] f, k, t, wn, wcur;
	logic [3:0]  wi;
	logic [4:0]  sh;

	assign q_ready = (state_q == S_IDLE);
	assign wcur = (rnd_q < 7'd16) ? w_q[rnd_q[3:0]] : wn;
	assign wn = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 5'd1);
	assign wi = fill_q[5:2];
	assign sh = 5'(24 - 8 * fill_q[1:0]);

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = rotl(a_q, 5'd5) + f + e_q + k + wcur;
	end

	// message schedule: 16-word window that shifts once per round from round 16
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid && q_req.has_byte) begin
					if (fill_q[1:0] == 2'd0) begin
						w_q[wi] <= {24'd0, q_req.data_byte} << sh;
					end else begin
						w_q[wi] <= w_q[wi] | ({24'd0, q_req.data_byte} << sh);
					end
				end
			end
			S_PAD: begin
				if (widx_q == wi) begin
					if (fill_q[1:0] == 2'd0) begin
						w_q[wi] <= {24'd0, PAD_BYTE} << sh;
					end else begin
						w_q[wi] <= w_q[wi] | ({24'd0, PAD_BYTE} << sh);
					end
				end else if (widx_q > wi) begin
					w_q[widx_q] <= '0;
				end
			end
			S_COMP: begin
				if (rnd_q >= 7'd16) begin
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i+1];
					end
					w_q[15] <= wn;
				end
			end
			S_ADD: begin
				if (fin_q && need2_q) begin
					for (int i = 0; i < 14; i++) begin
						w_q[i] <= '0;
					end
				end
			end
			S_LEN: begin
				w_q[14] <= bits_q[63:32];
				w_q[15] <= bits_q[31:0];
			end
			default: begin
			end
		endcase
	end

	// From round 16 on the window holds w[r-16..r-1]; each round shifts in w[r].

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q <= '{IV0, IV1, IV2, IV3, IV4};
			fill_q <= '0;
			bits_q <= '0;
			fin_q <= 1'b0;
			need2_q <= 1'b0;
			pad_done_q <= 1'b0;
			rnd_q <= '0;
			widx_q <= '0;
			oidx_q <= '0;
			out_valid <= 1'b0;
			digest_word <= '0;
			word_index <= '0;
			last_word <= 1'b0;
			{a_q, b_q, c_q, d_q, e_q} <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						fin_q <= q_req.end_of_message;
						pad_done_q <= 1'b0;
						{a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
						rnd_q <= '0;
						if (q_req.has_byte) begin
							fill_q <= fill_q + 1'b1;
							bits_q <= bits_q + 64'd8;
							if (fill_q == 6'd63) begin
								state_q <= S_COMP;
							end else if (q_req.end_of_message) begin
								widx_q <= '0;
								state_q <= S_PAD;
							end
						end else begin
							widx_q <= '0;
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					widx_q <= widx_q + 1'b1;
					if (widx_q == 4'd15) begin
						need2_q <= (fill_q >= 6'd56);
						pad_done_q <= 1'b1;
						rnd_q <= '0;
						state_q <= (fill_q >= 6'd56) ? S_COMP : S_LEN;
					end
				end
				S_LEN: begin
					need2_q <= 1'b0;
					rnd_q <= '0;
					state_q <= S_COMP;
				end
				S_COMP: begin
					e_q <= d_q;
					d_q <= c_q;
					c_q <= rotl(b_q, 5'd30);
					b_q <= a_q;
					a_q <= t;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 7'd79) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					{a_q, b_q, c_q, d_q, e_q} <= {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q,
						h_q[3] + d_q, h_q[4] + e_q};
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (need2_q) begin
						state_q <= S_LEN;
					end else if (!pad_done_q) begin
						// full block on the final byte: pad an all-new block
						widx_q <= '0;
						state_q <= S_PAD;
					end else begin
						oidx_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						digest_word <= h_q[oidx_q];
						word_index <= oidx_q;
						last_word <= (oidx_q == 3'd4);
						oidx_q <= oidx_q + 1'b1;
						if (oidx_q == 3'd4) begin
							h_q <= '{IV0, IV1, IV2, IV3, IV4};
							fill_q <= '0;
							bits_q <= '0;
							fin_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q != S_EMIT && out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_only_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == S_IDLE) else $error("take outside idle");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMP |-> rnd_q < 7'd80) else $error("round overrun");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_word |-> word_index == 3'd4) else $error("bad last word");
`endif
endmodule

// ===== src/sha1_byte_stream_hasher.sv =====
// Top level of the SHA-1 byte stream hasher.
//
//  channel | signals                                   | direction
//  in      | in_valid in_ready data_byte has_byte end_of_message | request in
//  out     | out_valid out_ready digest_word word_index last_word | request out
//
// A byte is packed into the block while idle; every 64th byte starts the 80 rounds of
// one shared round unit and the chaining add. End of message adds the padding
// pass, loading of the length words, one or two compressions, and five output
// words.
// Reset restores the initial vector and zero counts at once; no clearing pass.
// A two-entry queue lets the front take requests while the back compresses.
// Requests with no byte and no end are accepted and dropped.
module sha1_byte_stream_hasher import sha1_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	logic      q_valid, q_ready;
	sha1_req_t q_req;

	// hold requests in the queue while the back end compresses
	sha1_front #(.DEPTH(DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .has_byte,
		.end_of_message, .q_valid, .q_ready, .q_req
	);

	sha1_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req, .out_valid, .out_ready,
		.digest_word, .word_index, .last_word
	);
endmodule
